>>> rtl/core/tadc_pkg.sv
package tadc_pkg;

  localparam int ADC_BITS = 12;
  localparam int OHM_W    = 24;
  localparam int COEF_W   = 48;
  localparam int CFG_W    = COEF_W;
  localparam int NUM_W    = OHM_W + ADC_BITS;
  localparam int N_W      = 2 * OHM_W + ADC_BITS;

  localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

  localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
  localparam logic signed [63:0] KELVIN_Q8    = 64'sd1118822;
  localparam logic signed [63:0] ROUND_HALF   = 64'sd128;
  localparam logic signed [15:0] MIN_RESET    = 16'sd15984;
  localparam logic signed [15:0] MAX_RESET    = 16'sd0;
  localparam logic signed [15:0] TEMP_INVALID = 16'sd32767;

  localparam int SQ_STEPS    = 32;
  localparam int SQ_CNT_W    = $clog2(SQ_STEPS);
  localparam int RECIP_SHIFT = 60;
  localparam int QUO_W       = RECIP_SHIFT + 1;

  typedef enum logic [2:0] {
    REG_CUBIC,
    REG_SERIES,
    REG_PARALLEL,
    REG_NOMINAL,
    REG_COEF_A,
    REG_COEF_B,
    REG_COEF_C
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INVALID,
    OP_MUL,
    OP_WB,
    OP_NOPAR,
    OP_LN_INIT,
    OP_NORM,
    OP_SQ_INIT,
    OP_SQ,
    OP_DIV,
    OP_TEMP,
    OP_FINISH
  } dp_op_t;

  typedef enum logic [3:0] {
    MS_NUM,
    MS_PD,
    MS_N,
    MS_KD,
    MS_LN,
    MS_BL,
    MS_LL,
    MS_L3,
    MS_CL3
  } mul_sel_t;

  typedef enum logic [1:0] {
    LN_N,
    LN_D,
    LN_R0
  } ln_src_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t msel;
    ln_src_t  lsrc;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_bad;
    logic par_absent;
    logic par_bad;
    logic open_bad;
    logic cubic;
    logic sum_zero;
    logic norm_done;
    logic mul_done;
    logic div_done;
  } dp_stat_t;

  typedef struct packed {
    logic                    use_cubic_mode;
    logic [OHM_W-1:0]        series_ohms;
    logic [OHM_W-1:0]        parallel_ohms;
    logic [OHM_W-1:0]        nominal_ohms;
    logic signed [COEF_W-1:0] coef_a;
    logic signed [COEF_W-1:0] coef_b;
    logic signed [COEF_W-1:0] coef_c;
  } cfg_t;

  typedef struct packed {
    logic                command;
    logic [ADC_BITS-1:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic               invalid;
    logic signed [15:0] lowest_seen;
    logic signed [15:0] highest_seen;
  } out_t;

endpackage

>>> rtl/core/tadc_mul.sv
// 64x64 unsigned multiply, four 32x32 partial products, one per cycle.
module tadc_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod,
  output logic         done
);

  localparam logic [2:0] PARTS = 3'd4;

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [63:0]  pp;
  logic [2:0]   step;
  logic         run;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [2:0]   pidx;
  logic [127:0] addend;

  assign pa   = step[1] ? a_r[63:32] : a_r[31:0];
  assign pb   = step[0] ? b_r[63:32] : b_r[31:0];
  assign pidx = step - 3'd1;

  always_comb begin
    case (pidx[1:0])
      2'd0:    addend = {64'b0, pp};
      2'd3:    addend = {pp, 64'b0};
      default: addend = {32'b0, pp, 32'b0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        prod <= '0;
        step <= '0;
        run  <= 1'b1;
      end else if (run) begin
        if (step < PARTS) begin
          pp <= pa * pb;
        end
        if (step != 3'd0) begin
          prod <= prod + addend;
        end
        if (step == PARTS) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 3'd1;
      end
    end
  end

endmodule

>>> rtl/core/tadc_div.sv
// Restoring divider: 2^RECIP_SHIFT / divisor, one quotient bit per cycle.
module tadc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                divisor,
  output logic [tadc_pkg::QUO_W-1:0] quo,
  output logic                       done
);

  logic [63:0] rem;
  logic [63:0] dv;
  logic [5:0]  cnt;
  logic        run;
  logic [64:0] t;
  logic [64:0] diff;
  logic        ge;

  assign t    = {rem, cnt == 6'(tadc_pkg::RECIP_SHIFT)};
  assign ge   = t >= {1'b0, dv};
  assign diff = t - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        dv  <= divisor;
        quo <= '0;
        cnt <= 6'(tadc_pkg::RECIP_SHIFT);
        run <= 1'b1;
      end else if (run) begin
        rem <= ge ? diff[63:0] : t[63:0];
        quo <= {quo[tadc_pkg::QUO_W-2:0], ge};
        if (cnt == 6'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

endmodule

>>> rtl/core/tadc_dp.sv
// Datapath: resistance ratio, log2 by squaring, Q32 products, reciprocal, trackers.
module tadc_dp (
  input  logic              clk,
  input  logic              rst,
  input  tadc_pkg::cfg_t    cfg,
  input  tadc_pkg::in_t     in_data,
  input  tadc_pkg::dp_cmd_t cmd,
  output tadc_pkg::dp_stat_t stat,
  output tadc_pkg::out_t    result
);

  localparam logic signed [63:0] I64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] I64_MIN = {1'b1, 63'b0};
  localparam logic signed [55:0] T_MAX   = 56'sd32767;
  localparam logic signed [55:0] T_MIN   = -56'sd32768;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  // (a*b)>>32 from magnitude product, truncated toward zero, saturated
  function automatic logic signed [63:0] q32(input logic [127:0] p, input logic neg);
    logic [63:0]        m;
    logic signed [63:0] r;
    m = p[95:32];
    if (p[127:96] != 32'd0) begin
      r = neg ? I64_MIN : I64_MAX;
    end else if (neg) begin
      r = m[63] ? I64_MIN : -$signed(m);
    end else begin
      r = m[63] ? I64_MAX : $signed(m);
    end
    q32 = r;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic signed [64:0] s;
    s = {x[63], x} + {y[63], y};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? I64_MIN : I64_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  logic                              restart_r;
  logic [tadc_pkg::ADC_BITS-1:0]     s_r;
  logic [tadc_pkg::ADC_BITS-1:0]     den_r;
  logic [tadc_pkg::NUM_W-1:0]        num_r;
  logic [tadc_pkg::NUM_W-1:0]        pd_r;
  logic [tadc_pkg::N_W-1:0]          n_r;
  logic [tadc_pkg::NUM_W-1:0]        d_r;
  logic                              open_r;
  logic [63:0]                       x_r;
  logic [5:0]                        sh_r;
  logic [31:0]                       m_r;
  logic [31:0]                       frac_r;
  logic signed [63:0]                l_r;
  logic signed [63:0]                lsq_r;
  logic signed [63:0]                l3_r;
  logic signed [63:0]                sum_r;
  logic signed [15:0]                temp_r;
  logic                              valid_r;
  logic signed [15:0]                min_r;
  logic signed [15:0]                max_r;

  logic [63:0]                       ua;
  logic [63:0]                       ub;
  logic                              mneg;
  logic [127:0]                      prod;
  logic                              mul_done;
  logic [tadc_pkg::QUO_W-1:0]        quo;
  logic                              div_done;
  logic signed [63:0]                qv;
  logic signed [63:0]                lnv;
  logic signed [63:0]                a_ext;
  logic signed [63:0]                b_ext;
  logic signed [63:0]                c_ext;
  logic [5:0]                        e_val;
  logic [63:0]                       sq;
  logic [63:0]                       qx;
  logic signed [63:0]                qs;
  logic signed [63:0]                y;
  logic signed [55:0]                r;
  logic signed [15:0]                t_sat;

  assign a_ext = {{16{cfg.coef_a[47]}}, cfg.coef_a};
  assign b_ext = {{16{cfg.coef_b[47]}}, cfg.coef_b};
  assign c_ext = {{16{cfg.coef_c[47]}}, cfg.coef_c};
  assign e_val = 6'd63 - sh_r;
  assign sq    = m_r * m_r;
  assign qv    = q32(prod, mneg);
  assign lnv   = $signed(prod[95:32]);

  always_comb begin
    ua   = '0;
    ub   = '0;
    mneg = 1'b0;
    case (cmd.msel)
      tadc_pkg::MS_NUM: begin
        ua = 64'(cfg.series_ohms);
        ub = 64'(s_r);
      end
      tadc_pkg::MS_PD: begin
        ua = 64'(cfg.parallel_ohms);
        ub = 64'(den_r);
      end
      tadc_pkg::MS_N: begin
        ua = 64'(cfg.parallel_ohms);
        ub = 64'(num_r);
      end
      tadc_pkg::MS_KD: begin
        ua = 64'({cfg.nominal_ohms, 3'b000});
        ub = 64'(d_r);
      end
      tadc_pkg::MS_LN: begin
        ua = 64'({e_val, frac_r});
        ub = 64'(tadc_pkg::LN2_Q32);
      end
      tadc_pkg::MS_BL: begin
        ua   = mag64(b_ext);
        ub   = mag64(l_r);
        mneg = b_ext[63] ^ l_r[63];
      end
      tadc_pkg::MS_LL: begin
        ua = mag64(l_r);
        ub = mag64(l_r);
      end
      tadc_pkg::MS_L3: begin
        ua   = mag64(lsq_r);
        ub   = mag64(l_r);
        mneg = lsq_r[63] ^ l_r[63];
      end
      tadc_pkg::MS_CL3: begin
        ua   = mag64(c_ext);
        ub   = mag64(l3_r);
        mneg = c_ext[63] ^ l3_r[63];
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  // reciprocal to 1/16 C, round half up (arithmetic shift floors)
  always_comb begin
    qx = 64'(quo);
    qs = sum_r[63] ? -$signed(qx) : $signed(qx);
    y  = qs - tadc_pkg::KELVIN_Q8 + tadc_pkg::ROUND_HALF;
    r  = 56'(y >>> 8);
    if (r > T_MAX) begin
      t_sat = 16'sd32767;
    end else if (r < T_MIN) begin
      t_sat = -16'sd32768;
    end else begin
      t_sat = r[15:0];
    end
  end

  tadc_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == tadc_pkg::OP_MUL),
    .a     (ua),
    .b     (ub),
    .prod  (prod),
    .done  (mul_done)
  );

  tadc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.op == tadc_pkg::OP_DIV),
    .divisor (mag64(sum_r)),
    .quo     (quo),
    .done    (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_r <= tadc_pkg::MIN_RESET;
      max_r <= tadc_pkg::MAX_RESET;
    end else begin
      case (cmd.op)
        tadc_pkg::OP_LOAD: begin
          restart_r <= in_data.command;
          s_r       <= in_data.adc_sample;
          den_r     <= tadc_pkg::FULL_SCALE - in_data.adc_sample;
          valid_r   <= 1'b1;
        end
        tadc_pkg::OP_INVALID: begin
          valid_r <= 1'b0;
          temp_r  <= tadc_pkg::TEMP_INVALID;
        end
        tadc_pkg::OP_NOPAR: begin
          n_r <= tadc_pkg::N_W'(num_r);
          d_r <= tadc_pkg::NUM_W'(den_r);
        end
        tadc_pkg::OP_WB: begin
          case (cmd.msel)
            tadc_pkg::MS_NUM: num_r <= prod[tadc_pkg::NUM_W-1:0];
            tadc_pkg::MS_PD:  pd_r  <= prod[tadc_pkg::NUM_W-1:0];
            tadc_pkg::MS_N: begin
              n_r <= prod[tadc_pkg::N_W-1:0];
              d_r <= pd_r - num_r;
            end
            tadc_pkg::MS_KD:  open_r <= 128'(n_r) > prod;
            tadc_pkg::MS_LN: begin
              if (cmd.lsrc == tadc_pkg::LN_N) begin
                l_r <= lnv;
              end else begin
                l_r <= l_r - lnv;
              end
            end
            tadc_pkg::MS_BL:  sum_r <= sat_add(a_ext, qv);
            tadc_pkg::MS_LL:  lsq_r <= qv;
            tadc_pkg::MS_L3:  l3_r  <= qv;
            tadc_pkg::MS_CL3: sum_r <= sat_add(sum_r, qv);
            default:          open_r <= open_r;
          endcase
        end
        tadc_pkg::OP_LN_INIT: begin
          sh_r <= '0;
          case (cmd.lsrc)
            tadc_pkg::LN_D:  x_r <= 64'(d_r);
            tadc_pkg::LN_R0: x_r <= 64'(cfg.nominal_ohms);
            default:         x_r <= 64'(n_r);
          endcase
        end
        tadc_pkg::OP_NORM: begin
          if (x_r[63:48] == 16'd0) begin
            x_r  <= {x_r[47:0], 16'b0};
            sh_r <= sh_r + 6'd16;
          end else if (!x_r[63]) begin
            x_r  <= {x_r[62:0], 1'b0};
            sh_r <= sh_r + 6'd1;
          end
        end
        tadc_pkg::OP_SQ_INIT: begin
          m_r    <= x_r[63:32];
          frac_r <= '0;
        end
        tadc_pkg::OP_SQ: begin
          if (sq[63]) begin
            m_r    <= sq[63:32];
            frac_r <= {frac_r[30:0], 1'b1};
          end else begin
            m_r    <= sq[62:31];
            frac_r <= {frac_r[30:0], 1'b0};
          end
        end
        tadc_pkg::OP_TEMP: temp_r <= t_sat;
        tadc_pkg::OP_FINISH: begin
          if (restart_r) begin
            if (valid_r) begin
              min_r <= temp_r;
              max_r <= temp_r;
            end else begin
              min_r <= tadc_pkg::MIN_RESET;
              max_r <= tadc_pkg::MAX_RESET;
            end
          end else if (valid_r) begin
            if (temp_r > max_r) max_r <= temp_r;
            if (temp_r < min_r) min_r <= temp_r;
          end
        end
        default: begin
          min_r <= min_r;
        end
      endcase
    end
  end

  assign stat.pre_bad    = (s_r == '0) || (s_r >= tadc_pkg::FULL_SCALE) ||
                           (cfg.series_ohms == '0) || (cfg.nominal_ohms == '0);
  assign stat.par_absent = cfg.parallel_ohms == '0;
  assign stat.par_bad    = num_r >= pd_r;
  assign stat.open_bad   = open_r;
  assign stat.cubic      = cfg.use_cubic_mode;
  assign stat.sum_zero   = sum_r == '0;
  assign stat.norm_done  = x_r[63];
  assign stat.mul_done   = mul_done;
  assign stat.div_done   = div_done;

  assign result.temperature  = temp_r;
  assign result.invalid      = !valid_r;
  assign result.lowest_seen  = min_r;
  assign result.highest_seen = max_r;

endmodule

>>> rtl/core/tadc_ctrl.sv
// Sequencer for one conversion.
module tadc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               out_room,
  input  tadc_pkg::dp_stat_t stat,
  output tadc_pkg::dp_cmd_t  cmd,
  output logic               idle,
  output logic               deliver
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MGO,
    S_MWAIT,
    S_NOPAR,
    S_PCHK,
    S_OCHK,
    S_LINIT,
    S_NORM,
    S_SQ,
    S_ZCHK,
    S_DIVW,
    S_INV,
    S_FIN,
    S_DONE
  } state_t;

  localparam logic [tadc_pkg::SQ_CNT_W-1:0] SQ_LAST =
    tadc_pkg::SQ_CNT_W'(tadc_pkg::SQ_STEPS - 1);

  state_t                          state, state_next;
  tadc_pkg::mul_sel_t              mstep, mstep_next;
  tadc_pkg::ln_src_t               lsrc, lsrc_next;
  logic [tadc_pkg::SQ_CNT_W-1:0]   sq_cnt, sq_cnt_next;

  always_comb begin
    state_next  = state;
    mstep_next  = mstep;
    lsrc_next   = lsrc;
    sq_cnt_next = sq_cnt;
    cmd.op      = tadc_pkg::OP_NONE;
    cmd.msel    = mstep;
    cmd.lsrc    = lsrc;
    deliver     = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op     = tadc_pkg::OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pre_bad) begin
          state_next = S_INV;
        end else begin
          mstep_next = tadc_pkg::MS_NUM;
          state_next = S_MGO;
        end
      end
      S_MGO: begin
        cmd.op     = tadc_pkg::OP_MUL;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          cmd.op = tadc_pkg::OP_WB;
          case (mstep)
            tadc_pkg::MS_NUM: begin
              if (stat.par_absent) begin
                state_next = S_NOPAR;
              end else begin
                mstep_next = tadc_pkg::MS_PD;
                state_next = S_MGO;
              end
            end
            tadc_pkg::MS_PD: state_next = S_PCHK;
            tadc_pkg::MS_N: begin
              mstep_next = tadc_pkg::MS_KD;
              state_next = S_MGO;
            end
            tadc_pkg::MS_KD: state_next = S_OCHK;
            tadc_pkg::MS_LN: begin
              case (lsrc)
                tadc_pkg::LN_N: begin
                  lsrc_next  = tadc_pkg::LN_D;
                  state_next = S_LINIT;
                end
                tadc_pkg::LN_D: begin
                  if (stat.cubic) begin
                    mstep_next = tadc_pkg::MS_BL;
                    state_next = S_MGO;
                  end else begin
                    lsrc_next  = tadc_pkg::LN_R0;
                    state_next = S_LINIT;
                  end
                end
                default: begin
                  mstep_next = tadc_pkg::MS_BL;
                  state_next = S_MGO;
                end
              endcase
            end
            tadc_pkg::MS_BL: begin
              if (stat.cubic) begin
                mstep_next = tadc_pkg::MS_LL;
                state_next = S_MGO;
              end else begin
                state_next = S_ZCHK;
              end
            end
            tadc_pkg::MS_LL: begin
              mstep_next = tadc_pkg::MS_L3;
              state_next = S_MGO;
            end
            tadc_pkg::MS_L3: begin
              mstep_next = tadc_pkg::MS_CL3;
              state_next = S_MGO;
            end
            tadc_pkg::MS_CL3: state_next = S_ZCHK;
            default:          state_next = S_INV;
          endcase
        end
      end
      S_NOPAR: begin
        cmd.op     = tadc_pkg::OP_NOPAR;
        mstep_next = tadc_pkg::MS_KD;
        state_next = S_MGO;
      end
      S_PCHK: begin
        if (stat.par_bad) begin
          state_next = S_INV;
        end else begin
          mstep_next = tadc_pkg::MS_N;
          state_next = S_MGO;
        end
      end
      S_OCHK: begin
        if (stat.open_bad) begin
          state_next = S_INV;
        end else begin
          lsrc_next  = tadc_pkg::LN_N;
          state_next = S_LINIT;
        end
      end
      S_LINIT: begin
        cmd.op     = tadc_pkg::OP_LN_INIT;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (stat.norm_done) begin
          cmd.op      = tadc_pkg::OP_SQ_INIT;
          sq_cnt_next = '0;
          state_next  = S_SQ;
        end else begin
          cmd.op = tadc_pkg::OP_NORM;
        end
      end
      S_SQ: begin
        cmd.op = tadc_pkg::OP_SQ;
        if (sq_cnt == SQ_LAST) begin
          mstep_next = tadc_pkg::MS_LN;
          state_next = S_MGO;
        end else begin
          sq_cnt_next = sq_cnt + 1'b1;
        end
      end
      S_ZCHK: begin
        if (stat.sum_zero) begin
          state_next = S_INV;
        end else begin
          cmd.op     = tadc_pkg::OP_DIV;
          state_next = S_DIVW;
        end
      end
      S_DIVW: begin
        if (stat.div_done) begin
          cmd.op     = tadc_pkg::OP_TEMP;
          state_next = S_FIN;
        end
      end
      S_INV: begin
        cmd.op     = tadc_pkg::OP_INVALID;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = tadc_pkg::OP_FINISH;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_room) begin
          deliver    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      mstep  <= tadc_pkg::MS_NUM;
      lsrc   <= tadc_pkg::LN_N;
      sq_cnt <= '0;
    end else begin
      state  <= state_next;
      mstep  <= mstep_next;
      lsrc   <= lsrc_next;
      sq_cnt <= sq_cnt_next;
    end
  end

  assign idle = state == S_IDLE;

endmodule

>>> rtl/core/thermistor_adc_to_temperature_unit.sv
// Thermistor divider reading to temperature in 1/16 C, with min/max tracking.
// Input channel (in_valid/in_ready/in_data): one beat is a command bit and a
// raw ADC sample. Output channel (out_valid/out_ready/out_data): one beat per
// input beat with temperature, invalid flag and the trackers after that beat.
// Configuration is a plain write port (cfg_we/cfg_index/cfg_data); write it
// only while no conversion is in flight. Unknown indexes are ignored.
// One conversion at a time. Readings rejected by the range checks finish far
// sooner than valid ones; a zero coefficient sum is only caught after the
// logarithms. The conversion time is set by the 32 squaring steps per
// logarithm on the squaring multiplier (three logs in beta mode, two in
// cubic), the 61-step radix-2 reciprocal divider, and the wide Q32 products
// that share one four-pass 32x32 multiplier.
// The output register parts the two sides: a finished beat waits there while
// the next sample is accepted and converted; if the receiver still stalls when
// that one finishes, the sequencer holds it and in_ready stays low.
// Synchronous reset restores the register defaults, sets the minimum tracker
// to 999 C and the maximum to zero, and empties the output register.
module thermistor_adc_to_temperature_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tadc_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tadc_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [2:0]                  cfg_index,
  input  logic [tadc_pkg::CFG_W-1:0]  cfg_data
);

  tadc_pkg::cfg_t     cfg;
  tadc_pkg::dp_cmd_t  cmd;
  tadc_pkg::dp_stat_t stat;
  tadc_pkg::out_t     result;
  logic               idle;
  logic               deliver;
  logic               start;
  logic               out_room;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.use_cubic_mode <= 1'b0;
      cfg.series_ohms    <= 24'd4700;
      cfg.parallel_ohms  <= 24'd0;
      cfg.nominal_ohms   <= 24'd100000;
      cfg.coef_a         <= '0;
      cfg.coef_b         <= '0;
      cfg.coef_c         <= '0;
    end else if (cfg_we) begin
      case (tadc_pkg::reg_idx_t'(cfg_index))
        tadc_pkg::REG_CUBIC:    cfg.use_cubic_mode <= cfg_data[0];
        tadc_pkg::REG_SERIES:   cfg.series_ohms    <= cfg_data[tadc_pkg::OHM_W-1:0];
        tadc_pkg::REG_PARALLEL: cfg.parallel_ohms  <= cfg_data[tadc_pkg::OHM_W-1:0];
        tadc_pkg::REG_NOMINAL:  cfg.nominal_ohms   <= cfg_data[tadc_pkg::OHM_W-1:0];
        tadc_pkg::REG_COEF_A:   cfg.coef_a         <= $signed(cfg_data);
        tadc_pkg::REG_COEF_B:   cfg.coef_b         <= $signed(cfg_data);
        tadc_pkg::REG_COEF_C:   cfg.coef_c         <= $signed(cfg_data);
        default:                cfg.use_cubic_mode <= cfg.use_cubic_mode;
      endcase
    end
  end

  // accept only when the sequencer is free
  assign in_ready = idle;
  assign start    = in_valid && in_ready;
  assign out_room = !out_valid || out_ready;

  tadc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .out_room (out_room),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle),
    .deliver  (deliver)
  );

  tadc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  // output register: holds a beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (deliver) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_data <= result;
    end
  end

endmodule
